[rtl/nat_pkg.sv]
// Shared types, codes and sizing helpers of the NUMA affinity table.
package nat_pkg;

   localparam int DEF_MAX_CPUS    = 64;
   localparam int DEF_MAX_RANGES  = 16;
   localparam int DEF_MAX_DOMAINS = 8;

   localparam logic [2:0] KIND_CLEAR     = 3'd0;
   localparam logic [2:0] KIND_ADD_CPU   = 3'd1;
   localparam logic [2:0] KIND_ADD_RANGE = 3'd2;
   localparam logic [2:0] KIND_FIND_ADDR = 3'd3;
   localparam logic [2:0] KIND_FIND_CPU  = 3'd4;

   typedef enum logic [1:0] {
      MODE_CPU   = 2'd0,
      MODE_RANGE = 2'd1,
      MODE_DOM   = 2'd2
   } scan_mode_type;

   typedef struct packed {
      logic          wr_cpu;
      logic          wr_rng;
      logic          wr_dom;
      scan_mode_type mode;
   } nat_store_ctl_type;

   function automatic int cnt_w(input int depth);
      return $clog2(depth + 1);
   endfunction

   function automatic int idx_w(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

[rtl/nat_req_if.sv]
// Request channel carrying one table operation.
interface nat_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] cpu_id;
   logic [31:0] domain;
   logic        enabled;
   logic [63:0] range_base;
   logic [63:0] range_length;
   logic [63:0] query_address;

   modport source (
      output valid, kind, cpu_id, domain, enabled, range_base, range_length,
             query_address,
      input  ready
   );

   modport sink (
      input  valid, kind, cpu_id, domain, enabled, range_base, range_length,
             query_address,
      output ready
   );
endinterface

[rtl/nat_rsp_if.sv]
// Response channel carrying the result of one table operation.
interface nat_rsp_if import nat_pkg::*; #(
   parameter int CPU_CNT_W = cnt_w(DEF_MAX_CPUS),
   parameter int RNG_CNT_W = cnt_w(DEF_MAX_RANGES),
   parameter int DOM_CNT_W = cnt_w(DEF_MAX_DOMAINS)
);
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [31:0]          found_domain;
   logic                 accepted;
   logic [CPU_CNT_W-1:0] cpus_held;
   logic [RNG_CNT_W-1:0] ranges_held;
   logic [DOM_CNT_W-1:0] domains_held;

   modport source (
      output valid, found, found_domain, accepted, cpus_held, ranges_held,
             domains_held,
      input  ready
   );

   modport sink (
      input  valid, found, found_domain, accepted, cpus_held, ranges_held,
             domains_held,
      output ready
   );
endinterface

[rtl/nat_store.sv]
// Entry memories of the affinity table with the match compare logic; CPU and domain scans share one equality compare.
module nat_store import nat_pkg::*; #(
   parameter int MAX_CPUS    = DEF_MAX_CPUS,
   parameter int MAX_RANGES  = DEF_MAX_RANGES,
   parameter int MAX_DOMAINS = DEF_MAX_DOMAINS,
   localparam int CpuIdxW = idx_w(MAX_CPUS),
   localparam int RngIdxW = idx_w(MAX_RANGES),
   localparam int DomIdxW = idx_w(MAX_DOMAINS),
   localparam int ScanW   = (cnt_w(MAX_CPUS) > cnt_w(MAX_RANGES))
                            ? ((cnt_w(MAX_CPUS) > cnt_w(MAX_DOMAINS))
                               ? cnt_w(MAX_CPUS) : cnt_w(MAX_DOMAINS))
                            : ((cnt_w(MAX_RANGES) > cnt_w(MAX_DOMAINS))
                               ? cnt_w(MAX_RANGES) : cnt_w(MAX_DOMAINS))
) (
   input  logic              clock,
   input  nat_store_ctl_type ctl,
   input  logic [CpuIdxW-1:0] wr_cpu_idx,
   input  logic [RngIdxW-1:0] wr_rng_idx,
   input  logic [DomIdxW-1:0] wr_dom_idx,
   input  logic [ScanW-1:0]  rd_idx,
   input  logic [31:0]       key_cpu_id,
   input  logic [31:0]       key_domain,
   input  logic              key_enabled,
   input  logic [63:0]       key_base,
   input  logic [63:0]       key_length,
   input  logic [63:0]       key_addr,
   output logic              hit,
   output logic [31:0]       hit_domain
);

   logic [31:0] cpu_id_mem  [0:MAX_CPUS-1];
   logic [31:0] cpu_dom_mem [0:MAX_CPUS-1];
   logic        cpu_en_mem  [0:MAX_CPUS-1];
   logic [63:0] rng_base_mem [0:MAX_RANGES-1];
   logic [63:0] rng_end_mem  [0:MAX_RANGES-1];
   logic [31:0] rng_dom_mem  [0:MAX_RANGES-1];
   logic        rng_en_mem   [0:MAX_RANGES-1];
   logic [31:0] dom_mem [0:MAX_DOMAINS-1];

   logic [31:0] rd_cpu_id_ff;
   logic [31:0] rd_cpu_dom_ff;
   logic        rd_cpu_en_ff;
   logic [63:0] rd_rng_base_ff;
   logic [63:0] rd_rng_end_ff;
   logic [31:0] rd_rng_dom_ff;
   logic        rd_rng_en_ff;
   logic [31:0] rd_dom_ff;

   logic [31:0] eq_a;
   logic [31:0] eq_b;
   logic        eq_hit;
   logic        rng_hit;

   always_ff @(posedge clock) begin
      if (ctl.wr_cpu) begin
         cpu_id_mem[wr_cpu_idx]  <= key_cpu_id;
         cpu_dom_mem[wr_cpu_idx] <= key_domain;
         cpu_en_mem[wr_cpu_idx]  <= key_enabled;
      end
      rd_cpu_id_ff  <= cpu_id_mem[rd_idx[CpuIdxW-1:0]];
      rd_cpu_dom_ff <= cpu_dom_mem[rd_idx[CpuIdxW-1:0]];
      rd_cpu_en_ff  <= cpu_en_mem[rd_idx[CpuIdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_rng) begin
         rng_base_mem[wr_rng_idx] <= key_base;
         rng_end_mem[wr_rng_idx]  <= key_base + key_length;
         rng_dom_mem[wr_rng_idx]  <= key_domain;
         rng_en_mem[wr_rng_idx]   <= key_enabled;
      end
      rd_rng_base_ff <= rng_base_mem[rd_idx[RngIdxW-1:0]];
      rd_rng_end_ff  <= rng_end_mem[rd_idx[RngIdxW-1:0]];
      rd_rng_dom_ff  <= rng_dom_mem[rd_idx[RngIdxW-1:0]];
      rd_rng_en_ff   <= rng_en_mem[rd_idx[RngIdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_dom) begin
         dom_mem[wr_dom_idx] <= key_domain;
      end
      rd_dom_ff <= dom_mem[rd_idx[DomIdxW-1:0]];
   end

   assign eq_a    = (ctl.mode == MODE_CPU) ? rd_cpu_id_ff : rd_dom_ff;
   assign eq_b    = (ctl.mode == MODE_CPU) ? key_cpu_id : key_domain;
   assign eq_hit  = (eq_a == eq_b);
   assign rng_hit = (key_addr >= rd_rng_base_ff) && (key_addr < rd_rng_end_ff);

   always_comb begin
      case (ctl.mode)
         MODE_CPU: begin
            hit        = rd_cpu_en_ff && eq_hit;
            hit_domain = rd_cpu_dom_ff;
         end
         MODE_RANGE: begin
            hit        = rd_rng_en_ff && rng_hit;
            hit_domain = rd_rng_dom_ff;
         end
         MODE_DOM: begin
            hit        = eq_hit;
            hit_domain = rd_dom_ff;
         end
         default: begin
            hit        = 1'b0;
            hit_domain = '0;
         end
      endcase
   end

endmodule

[rtl/numa_affinity_table_core.sv]
// Top level of the NUMA affinity table: sequencer, counters and response register.
// One operation is taken at a time and its result is held in an output register, so the
// next request is taken while a result still waits. Clear, a disabled add, an add into a full
// table and an unknown kind go from the execution step straight to completion. A lookup scans
// the stored entries through a single memory read port and compare unit, one entry per cycle,
// and stops at the first match. An enabled add scans the domain list the same way before it
// completes. The sequencer returns to idle, where it takes the next request, at the same edge
// at which the result moves into the output register, and a stalled response holds the
// sequencer in its last step.
module numa_affinity_table_core import nat_pkg::*; #(
   parameter int MAX_CPUS    = DEF_MAX_CPUS,
   parameter int MAX_RANGES  = DEF_MAX_RANGES,
   parameter int MAX_DOMAINS = DEF_MAX_DOMAINS
) (
   input  logic       clock,
   input  logic       reset,
   nat_req_if.sink    req_ch,
   nat_rsp_if.source  rsp_ch
);

   localparam int CpuCntW = cnt_w(MAX_CPUS);
   localparam int RngCntW = cnt_w(MAX_RANGES);
   localparam int DomCntW = cnt_w(MAX_DOMAINS);
   localparam int CpuIdxW = idx_w(MAX_CPUS);
   localparam int RngIdxW = idx_w(MAX_RANGES);
   localparam int DomIdxW = idx_w(MAX_DOMAINS);
   localparam int ScanW   = (CpuCntW > RngCntW)
                            ? ((CpuCntW > DomCntW) ? CpuCntW : DomCntW)
                            : ((RngCntW > DomCntW) ? RngCntW : DomCntW);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   scan_mode_type mode_ff, mode_in;
   logic [ScanW-1:0] idx_ff, idx_in;
   logic pend_ff, pend_in;
   logic [CpuCntW-1:0] cpu_count_ff, cpu_count_in;
   logic [RngCntW-1:0] rng_count_ff, rng_count_in;
   logic [DomCntW-1:0] dom_count_ff, dom_count_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [2:0]  kind_ff, kind_in;
   logic [31:0] cpu_id_ff, cpu_id_in;
   logic [31:0] domain_ff, domain_in;
   logic        enabled_ff, enabled_in;
   logic [63:0] base_ff, base_in;
   logic [63:0] length_ff, length_in;
   logic [63:0] addr_ff, addr_in;
   logic        found_ff, found_in;
   logic [31:0] fdom_ff, fdom_in;
   logic        acc_ff, acc_in;

   logic               rsp_found_ff, rsp_found_in;
   logic [31:0]        rsp_fdom_ff, rsp_fdom_in;
   logic               rsp_acc_ff, rsp_acc_in;
   logic [CpuCntW-1:0] rsp_cpus_ff, rsp_cpus_in;
   logic [RngCntW-1:0] rsp_rngs_ff, rsp_rngs_in;
   logic [DomCntW-1:0] rsp_doms_ff, rsp_doms_in;

   nat_store_ctl_type store_ctl;
   logic              hit;
   logic [31:0]       hit_domain;
   logic [ScanW-1:0]  scan_limit;

   nat_store #(
      .MAX_CPUS    (MAX_CPUS),
      .MAX_RANGES  (MAX_RANGES),
      .MAX_DOMAINS (MAX_DOMAINS)
   ) u_store (
      .clock       (clock),
      .ctl         (store_ctl),
      .wr_cpu_idx  (cpu_count_ff[CpuIdxW-1:0]),
      .wr_rng_idx  (rng_count_ff[RngIdxW-1:0]),
      .wr_dom_idx  (dom_count_ff[DomIdxW-1:0]),
      .rd_idx      (idx_ff),
      .key_cpu_id  (cpu_id_ff),
      .key_domain  (domain_ff),
      .key_enabled (enabled_ff),
      .key_base    (base_ff),
      .key_length  (length_ff),
      .key_addr    (addr_ff),
      .hit         (hit),
      .hit_domain  (hit_domain)
   );

   always_comb begin
      case (mode_ff)
         MODE_CPU:   scan_limit = ScanW'(cpu_count_ff);
         MODE_RANGE: scan_limit = ScanW'(rng_count_ff);
         MODE_DOM:   scan_limit = ScanW'(dom_count_ff);
         default:    scan_limit = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      cpu_count_in = cpu_count_ff;
      rng_count_in = rng_count_ff;
      dom_count_in = dom_count_ff;
      kind_in      = kind_ff;
      cpu_id_in    = cpu_id_ff;
      domain_in    = domain_ff;
      enabled_in   = enabled_ff;
      base_in      = base_ff;
      length_in    = length_ff;
      addr_in      = addr_ff;
      found_in     = found_ff;
      fdom_in      = fdom_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_fdom_in  = rsp_fdom_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_cpus_in  = rsp_cpus_ff;
      rsp_rngs_in  = rsp_rngs_ff;
      rsp_doms_in  = rsp_doms_ff;
      store_ctl        = '0;
      store_ctl.mode   = mode_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in    = req_ch.kind;
               cpu_id_in  = req_ch.cpu_id;
               domain_in  = req_ch.domain;
               enabled_in = req_ch.enabled;
               base_in    = req_ch.range_base;
               length_in  = req_ch.range_length;
               addr_in    = req_ch.query_address;
               found_in   = 1'b0;
               fdom_in    = '0;
               acc_in     = 1'b0;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            idx_in   = '0;
            pend_in  = 1'b0;
            state_in = ST_DONE;
            case (kind_ff)
               KIND_CLEAR: begin
                  cpu_count_in = '0;
                  rng_count_in = '0;
                  dom_count_in = '0;
               end
               KIND_ADD_CPU: begin
                  if (cpu_count_ff < CpuCntW'(MAX_CPUS)) begin
                     store_ctl.wr_cpu = 1'b1;
                     cpu_count_in     = cpu_count_ff + 1'b1;
                     acc_in           = 1'b1;
                     if (enabled_ff) begin
                        mode_in  = MODE_DOM;
                        state_in = ST_SCAN;
                     end
                  end
               end
               KIND_ADD_RANGE: begin
                  if (rng_count_ff < RngCntW'(MAX_RANGES)) begin
                     store_ctl.wr_rng = 1'b1;
                     rng_count_in     = rng_count_ff + 1'b1;
                     acc_in           = 1'b1;
                     if (enabled_ff) begin
                        mode_in  = MODE_DOM;
                        state_in = ST_SCAN;
                     end
                  end
               end
               KIND_FIND_ADDR: begin
                  mode_in  = MODE_RANGE;
                  state_in = ST_SCAN;
               end
               KIND_FIND_CPU: begin
                  mode_in  = MODE_CPU;
                  state_in = ST_SCAN;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (pend_ff && hit) begin
               state_in = ST_DONE;
               if (mode_ff != MODE_DOM) begin
                  found_in = 1'b1;
                  fdom_in  = hit_domain;
               end
            end else if (!pend_ff && (idx_ff == scan_limit)) begin
               state_in = ST_DONE;
               if ((mode_ff == MODE_DOM) && (dom_count_ff < DomCntW'(MAX_DOMAINS))) begin
                  store_ctl.wr_dom = 1'b1;
                  dom_count_in     = dom_count_ff + 1'b1;
               end
            end else if (idx_ff != scan_limit) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_fdom_in  = fdom_ff;
               rsp_acc_in   = acc_ff;
               rsp_cpus_in  = cpu_count_ff;
               rsp_rngs_in  = rng_count_ff;
               rsp_doms_in  = dom_count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_CPU;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         cpu_count_ff <= '0;
         rng_count_ff <= '0;
         dom_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         cpu_count_ff <= cpu_count_in;
         rng_count_ff <= rng_count_in;
         dom_count_ff <= dom_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      cpu_id_ff    <= cpu_id_in;
      domain_ff    <= domain_in;
      enabled_ff   <= enabled_in;
      base_ff      <= base_in;
      length_ff    <= length_in;
      addr_ff      <= addr_in;
      found_ff     <= found_in;
      fdom_ff      <= fdom_in;
      acc_ff       <= acc_in;
      rsp_found_ff <= rsp_found_in;
      rsp_fdom_ff  <= rsp_fdom_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_cpus_ff  <= rsp_cpus_in;
      rsp_rngs_ff  <= rsp_rngs_in;
      rsp_doms_ff  <= rsp_doms_in;
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.found_domain = rsp_fdom_ff;
   assign rsp_ch.accepted     = rsp_acc_ff;
   assign rsp_ch.cpus_held    = rsp_cpus_ff;
   assign rsp_ch.ranges_held  = rsp_rngs_ff;
   assign rsp_ch.domains_held = rsp_doms_ff;

`ifndef SYNTH
   a_cpu_count_bound: assert property (@(posedge clock) disable iff (reset)
      cpu_count_ff <= CpuCntW'(MAX_CPUS))
      else $error("CPU entry count exceeds the table depth.");

   a_dom_count_bound: assert property (@(posedge clock) disable iff (reset)
      dom_count_ff <= DomCntW'(MAX_DOMAINS))
      else $error("Domain list count exceeds the list depth.");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= scan_limit))
      else $error("Scan index ran past the stored entries.");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("Response transfer offered outside the completion step.");
`endif

endmodule
